@@ sv/huffman_code_builder_unit_assert.svh @@
// Assertion macros for the Huffman code builder.
// Included by huffman_code_builder_unit.sv; expects clk and rst_n in scope.
`ifndef HUFFMAN_CODE_BUILDER_UNIT_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/hcb_pkg.sv @@
// Package for the Huffman code builder: sizes, beat structs and storage entry types.
// No dependencies; used by huffman_code_builder_unit.sv.
package hcb_pkg;

    localparam int MAX_SYMBOLS = 32;
    localparam int FREQ_BITS   = 24;
    localparam int SYMBOL_BITS = 8;
    localparam int SLOT_BITS   = $clog2(MAX_SYMBOLS);
    localparam int COUNT_BITS  = SLOT_BITS + 1;
    localparam int NODE_BITS   = $clog2(2 * MAX_SYMBOLS - 1);
    localparam int WEIGHT_BITS = FREQ_BITS + SLOT_BITS + 1;
    localparam int CODE_BITS   = 31;
    localparam int LEN_BITS    = 5;

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] symbol;
        logic [FREQ_BITS-1:0]   frequency;
        logic                   last_symbol;
    } sym_beat_t;

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] code_symbol;
        logic [CODE_BITS-1:0]   code_bits;
        logic [LEN_BITS-1:0]    code_length;
        logic                   last_code;
        logic                   overflow;
    } code_beat_t;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] weight;
        logic [NODE_BITS-1:0]   node;
    } heap_entry_t;

    typedef struct packed {
        logic [NODE_BITS-1:0] zero_node;
        logic [NODE_BITS-1:0] one_node;
    } child_pair_t;

    typedef struct packed {
        logic [NODE_BITS-1:0] node;
        logic [CODE_BITS-1:0] code;
        logic [LEN_BITS-1:0]  depth;
    } walk_entry_t;

endpackage

@@ sv/huffman_code_builder_unit.sv @@
// Huffman code builder: loads (symbol, frequency) beats into a min-heap, builds the tree
// on the last beat and emits one code beat per leaf. Uses hcb_pkg and the assert header.
// A load sifts the new entry up through the heap memory, with one read and one compare per
// level. After the last beat each merge takes two sift-downs and one sift-up; the walk then
// visits each inner node and each leaf in turn, and an emit may stall on the output.
// No beat is accepted meanwhile. Reset clears counters and flags; memories need no clearing.
`include "huffman_code_builder_unit_assert.svh"

module huffman_code_builder_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sym_valid,
    output logic               sym_ready,
    input  hcb_pkg::sym_beat_t sym_data,
    output logic               code_valid,
    input  logic               code_ready,
    output hcb_pkg::code_beat_t code_data
);

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_UP        = 15'b000000000000010,
        S_UP_CMP    = 15'b000000000000100,
        S_BUILD_CHK = 15'b000000000001000,
        S_POP       = 15'b000000000010000,
        S_POP_SET   = 15'b000000000100000,
        S_DN        = 15'b000000001000000,
        S_DN_CMP    = 15'b000000010000000,
        S_MERGE     = 15'b000000100000000,
        S_ROOT_RD   = 15'b000001000000000,
        S_ROOT      = 15'b000010000000000,
        S_WALK      = 15'b000100000000000,
        S_EMIT      = 15'b001000000000000,
        S_POPST     = 15'b010000000000000,
        S_CHILD     = 15'b100000000000000
    } state_t;

    localparam int SB = hcb_pkg::SLOT_BITS;
    localparam int CB = hcb_pkg::COUNT_BITS;
    localparam int NB = hcb_pkg::NODE_BITS;

    hcb_pkg::heap_entry_t heap_mem [hcb_pkg::MAX_SYMBOLS];
    logic [hcb_pkg::SYMBOL_BITS-1:0] leaf_mem [hcb_pkg::MAX_SYMBOLS];
    hcb_pkg::child_pair_t child_mem [hcb_pkg::MAX_SYMBOLS];
    hcb_pkg::walk_entry_t stack_mem [hcb_pkg::MAX_SYMBOLS];

    state_t state_reg, state_next;
    logic [CB-1:0] heap_count_reg, heap_count_next;
    logic [CB-1:0] node_count_reg, node_count_next;
    logic dropped_reg, dropped_next;
    logic build_reg, build_next;
    logic phase_reg, phase_next;
    logic [SB-1:0] hole_reg, hole_next;
    logic [NB-1:0] next_node_reg, next_node_next;
    hcb_pkg::heap_entry_t x_reg, x_next;
    hcb_pkg::heap_entry_t a_reg, a_next;
    hcb_pkg::heap_entry_t top_reg, top_next;
    hcb_pkg::walk_entry_t cur_reg, cur_next;
    logic [CB-1:0] sp_reg, sp_next;
    logic out_valid_reg, out_valid_next;
    hcb_pkg::code_beat_t out_reg, out_next;

    logic hw_en;
    logic [SB-1:0] hw_addr;
    hcb_pkg::heap_entry_t hw_data;
    logic hr_en;
    logic [SB-1:0] hr1_addr, hr2_addr;
    hcb_pkg::heap_entry_t hr1_data, hr2_data;

    logic lw_en;
    logic lr_en;
    logic [SB-1:0] lr_addr;
    logic [hcb_pkg::SYMBOL_BITS-1:0] lr_data;

    logic cw_en;
    logic [SB-1:0] cw_addr;
    hcb_pkg::child_pair_t cw_data;
    logic cr_en;
    logic [SB-1:0] cr_addr;
    hcb_pkg::child_pair_t cr_data;

    logic sw_en;
    logic [SB-1:0] sw_addr;
    hcb_pkg::walk_entry_t sw_data;
    logic sr_en;
    logic [SB-1:0] sr_addr;
    hcb_pkg::walk_entry_t sr_data;

    logic sym_take;
    logic out_free;
    logic [SB-1:0] parent_idx;
    logic [SB+1:0] left_idx, right_idx;
    logic left_win, right_win;
    logic [hcb_pkg::WEIGHT_BITS-1:0] small_w;
    logic [NB-1:0] node_sub;

    always_ff @(posedge clk)
    begin
        if (hw_en)
        begin
            heap_mem[hw_addr] <= hw_data;
        end
        if (hr_en)
        begin
            hr1_data <= heap_mem[hr1_addr];
            hr2_data <= heap_mem[hr2_addr];
        end
        if (lw_en)
        begin
            leaf_mem[node_count_reg[SB-1:0]] <= sym_data.symbol;
        end
        if (lr_en)
        begin
            lr_data <= leaf_mem[lr_addr];
        end
        if (cw_en)
        begin
            child_mem[cw_addr] <= cw_data;
        end
        if (cr_en)
        begin
            cr_data <= child_mem[cr_addr];
        end
        if (sw_en)
        begin
            stack_mem[sw_addr] <= sw_data;
        end
        if (sr_en)
        begin
            sr_data <= stack_mem[sr_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            heap_count_reg <= '0;
            node_count_reg <= '0;
            dropped_reg    <= 1'b0;
            build_reg      <= 1'b0;
            phase_reg      <= 1'b0;
            sp_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            heap_count_reg <= heap_count_next;
            node_count_reg <= node_count_next;
            dropped_reg    <= dropped_next;
            build_reg      <= build_next;
            phase_reg      <= phase_next;
            sp_reg         <= sp_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg      <= hole_next;
        next_node_reg <= next_node_next;
        x_reg         <= x_next;
        a_reg         <= a_next;
        top_reg       <= top_next;
        cur_reg       <= cur_next;
        out_reg       <= out_next;
    end

    assign sym_ready  = (state_reg == S_IDLE);
    assign sym_take   = sym_valid && sym_ready;
    assign out_free   = !out_valid_reg || code_ready;
    assign code_valid = out_valid_reg;
    assign code_data  = out_reg;

    assign parent_idx = (hole_reg - SB'(1)) >> 1;
    assign left_idx   = {1'b0, hole_reg, 1'b1};
    assign right_idx  = {1'b0, hole_reg, 1'b0} + (SB+2)'(2);
    assign left_win   = (left_idx < (SB+2)'(heap_count_reg))
                        && (hr1_data.weight < x_reg.weight);
    assign small_w    = left_win ? hr1_data.weight : x_reg.weight;
    assign right_win  = (right_idx < (SB+2)'(heap_count_reg))
                        && (hr2_data.weight < small_w);
    assign node_sub   = cur_reg.node - NB'(node_count_reg);

    always_comb
    begin
        state_next      = state_reg;
        heap_count_next = heap_count_reg;
        node_count_next = node_count_reg;
        dropped_next    = dropped_reg;
        build_next      = build_reg;
        phase_next      = phase_reg;
        hole_next       = hole_reg;
        next_node_next  = next_node_reg;
        x_next          = x_reg;
        a_next          = a_reg;
        top_next        = top_reg;
        cur_next        = cur_reg;
        sp_next         = sp_reg;
        out_valid_next  = out_valid_reg && !code_ready;
        out_next        = out_reg;

        hw_en    = 1'b0;
        hw_addr  = hole_reg;
        hw_data  = x_reg;
        hr_en    = 1'b0;
        hr1_addr = '0;
        hr2_addr = '0;
        lw_en    = 1'b0;
        lr_en    = 1'b0;
        lr_addr  = cur_reg.node[SB-1:0];
        cw_en    = 1'b0;
        cw_addr  = SB'(next_node_reg - NB'(node_count_reg));
        cw_data  = '{zero_node: a_reg.node, one_node: top_reg.node};
        cr_en    = 1'b0;
        cr_addr  = node_sub[SB-1:0];
        sw_en    = 1'b0;
        sw_addr  = sp_reg[SB-1:0];
        sw_data  = '{node: cr_data.one_node,
                     code: {cur_reg.code[hcb_pkg::CODE_BITS-2:0], 1'b1},
                     depth: cur_reg.depth + hcb_pkg::LEN_BITS'(1)};
        sr_en    = 1'b0;
        sr_addr  = SB'(sp_reg - CB'(1));

        case (state_reg)
            S_IDLE:
            begin
                if (sym_take)
                begin
                    build_next = sym_data.last_symbol;
                    if (node_count_reg < CB'(hcb_pkg::MAX_SYMBOLS))
                    begin
                        lw_en           = 1'b1;
                        x_next          = '{weight: hcb_pkg::WEIGHT_BITS'(sym_data.frequency),
                                            node: NB'(node_count_reg)};
                        hole_next       = heap_count_reg[SB-1:0];
                        heap_count_next = heap_count_reg + CB'(1);
                        node_count_next = node_count_reg + CB'(1);
                        next_node_next  = NB'(node_count_reg) + NB'(1);
                        state_next      = S_UP;
                    end
                    else
                    begin
                        dropped_next   = 1'b1;
                        next_node_next = NB'(node_count_reg);
                        if (sym_data.last_symbol)
                        begin
                            state_next = S_BUILD_CHK;
                        end
                    end
                end
            end
            S_UP:
            begin
                if (hole_reg == '0)
                begin
                    hw_en      = 1'b1;
                    state_next = build_reg ? S_BUILD_CHK : S_IDLE;
                end
                else
                begin
                    hr_en      = 1'b1;
                    hr1_addr   = parent_idx;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                hw_en = 1'b1;
                if (hr1_data.weight > x_reg.weight)
                begin
                    hw_data    = hr1_data;
                    hole_next  = parent_idx;
                    state_next = S_UP;
                end
                else
                begin
                    state_next = build_reg ? S_BUILD_CHK : S_IDLE;
                end
            end
            S_BUILD_CHK:
            begin
                phase_next = 1'b0;
                if (heap_count_reg > CB'(1))
                begin
                    state_next = S_POP;
                end
                else if (heap_count_reg == CB'(1))
                begin
                    state_next = S_ROOT_RD;
                end
                else
                begin
                    node_count_next = '0;
                    dropped_next    = 1'b0;
                    build_next      = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            S_POP:
            begin
                hr_en           = 1'b1;
                hr1_addr        = '0;
                hr2_addr        = SB'(heap_count_reg - CB'(1));
                heap_count_next = heap_count_reg - CB'(1);
                state_next      = S_POP_SET;
            end
            S_POP_SET:
            begin
                if (phase_reg)
                begin
                    top_next = hr1_data;
                end
                else
                begin
                    a_next = hr1_data;
                end
                x_next     = hr2_data;
                hole_next  = '0;
                state_next = S_DN;
            end
            S_DN:
            begin
                hr_en      = 1'b1;
                hr1_addr   = left_idx[SB-1:0];
                hr2_addr   = right_idx[SB-1:0];
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                hw_en = 1'b1;
                if (right_win)
                begin
                    hw_data    = hr2_data;
                    hole_next  = right_idx[SB-1:0];
                    state_next = S_DN;
                end
                else if (left_win)
                begin
                    hw_data    = hr1_data;
                    hole_next  = left_idx[SB-1:0];
                    state_next = S_DN;
                end
                else if (phase_reg)
                begin
                    state_next = S_MERGE;
                end
                else
                begin
                    phase_next = 1'b1;
                    state_next = S_POP;
                end
            end
            S_MERGE:
            begin
                cw_en           = 1'b1;
                x_next          = '{weight: a_reg.weight + top_reg.weight,
                                    node: next_node_reg};
                hole_next       = heap_count_reg[SB-1:0];
                heap_count_next = heap_count_reg + CB'(1);
                next_node_next  = next_node_reg + NB'(1);
                state_next      = S_UP;
            end
            S_ROOT_RD:
            begin
                hr_en      = 1'b1;
                hr1_addr   = '0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cur_next   = '{node: hr1_data.node, code: '0, depth: '0};
                sp_next    = '0;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (cur_reg.node < NB'(node_count_reg))
                begin
                    lr_en      = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    cr_en      = 1'b1;
                    state_next = S_CHILD;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{code_symbol: lr_data,
                                       code_bits: cur_reg.code,
                                       code_length: cur_reg.depth,
                                       last_code: (sp_reg == '0),
                                       overflow: dropped_reg};
                    if (sp_reg == '0)
                    begin
                        heap_count_next = '0;
                        node_count_next = '0;
                        dropped_next    = 1'b0;
                        build_next      = 1'b0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        sr_en      = 1'b1;
                        sp_next    = sp_reg - CB'(1);
                        state_next = S_POPST;
                    end
                end
            end
            S_POPST:
            begin
                cur_next   = sr_data;
                state_next = S_WALK;
            end
            S_CHILD:
            begin
                sw_en      = 1'b1;
                sp_next    = sp_reg + CB'(1);
                cur_next   = '{node: cr_data.zero_node,
                               code: {cur_reg.code[hcb_pkg::CODE_BITS-2:0], 1'b0},
                               depth: cur_reg.depth + hcb_pkg::LEN_BITS'(1)};
                state_next = S_WALK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `HCB_ASSERT_SAME(a_heap_bound, 1'b1, heap_count_reg <= node_count_reg, "heap exceeds leaf count")
    `HCB_ASSERT_SAME(a_count_cap, 1'b1, node_count_reg <= CB'(hcb_pkg::MAX_SYMBOLS), "leaf count over capacity")
    `HCB_ASSERT_NEXT(a_run_clear, state_reg == S_EMIT && out_free && sp_reg == '0, node_count_reg == '0 && !dropped_reg && out_valid_reg && out_reg.last_code, "run end not cleared")
    `HCB_ASSERT_NEXT(a_out_hold, out_valid_reg && !code_ready, out_valid_reg && $stable(out_reg), "pending code beat changed")

endmodule

@@ tb/huffman_code_builder_unit_tb.sv @@
// Self-checking testbench for huffman_code_builder_unit: drives symbol beats, predicts
// the code beats of each run with a behavioral Huffman builder and compares them in order.
// Depends on hcb_pkg and the RTL of huffman_code_builder_unit.
module huffman_code_builder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_MAX    = 2 * hcb_pkg::MAX_SYMBOLS - 1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RAND_ITEMS  = 200;

    typedef struct packed {
        hcb_pkg::sym_beat_t  beat;
        logic                typed;
        hcb_pkg::code_beat_t code;
    } dir_row_t;

    typedef struct {
        int          node;
        longint unsigned code;
        int          depth;
    } walk_t;

    logic                clk;
    logic                rst_n;
    logic                sym_valid;
    logic                sym_ready;
    hcb_pkg::sym_beat_t  sym_data;
    logic                code_valid;
    logic                code_ready;
    hcb_pkg::code_beat_t code_data;

    hcb_pkg::code_beat_t pending_codes[$];
    int              error_count;
    int              cycle_count;
    int              codes_seen;
    int              runs_sent;
    int              beats_sent;
    bit              quiet;

    int              heap_node[hcb_pkg::MAX_SYMBOLS];
    int              heap_size;
    longint unsigned node_weight[NODE_MAX];
    logic [7:0]      leaf_sym[hcb_pkg::MAX_SYMBOLS];
    int              zero_node[hcb_pkg::MAX_SYMBOLS];
    int              one_node[hcb_pkg::MAX_SYMBOLS];
    int              leaf_total;
    bit              symbols_dropped;

    huffman_code_builder_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .sym_data  (sym_data),
        .code_valid(code_valid),
        .code_ready(code_ready),
        .code_data (code_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic longint unsigned slot_weight(int slot);
        return node_weight[heap_node[slot]];
    endfunction

    function automatic void heap_push(int node);
        int i;
        int t;
        if (heap_size >= hcb_pkg::MAX_SYMBOLS)
            return;
        i = heap_size;
        heap_size++;
        heap_node[i] = node;
        while (i != 0 && slot_weight((i - 1) / 2) > slot_weight(i))
        begin
            t = heap_node[i];
            heap_node[i] = heap_node[(i - 1) / 2];
            heap_node[(i - 1) / 2] = t;
            i = (i - 1) / 2;
        end
    endfunction

    function automatic int heap_pop();
        int top;
        int i;
        int s;
        int t;
        top = heap_node[0];
        i = 0;
        if (heap_size == 0)
            return top;
        heap_size--;
        heap_node[0] = heap_node[heap_size];
        forever
        begin
            s = i;
            if (2 * i + 1 < heap_size && slot_weight(2 * i + 1) < slot_weight(s))
                s = 2 * i + 1;
            if (2 * i + 2 < heap_size && slot_weight(2 * i + 2) < slot_weight(s))
                s = 2 * i + 2;
            if (s == i)
                break;
            t = heap_node[i];
            heap_node[i] = heap_node[s];
            heap_node[s] = t;
            i = s;
        end
        return top;
    endfunction

    function automatic void predict_codes(hcb_pkg::sym_beat_t beat);
        int                  leaves;
        int                  next_node;
        int                  a;
        int                  b;
        int                  k;
        walk_t               stack[$];
        walk_t               w;
        hcb_pkg::code_beat_t c;
        int                  first_new;
        if (leaf_total < hcb_pkg::MAX_SYMBOLS)
        begin
            node_weight[leaf_total] = 64'(beat.frequency);
            leaf_sym[leaf_total] = beat.symbol;
            heap_push(leaf_total);
            leaf_total++;
        end
        else
            symbols_dropped = 1'b1;
        if (!beat.last_symbol)
            return;
        leaves = leaf_total;
        next_node = leaves;
        while (heap_size > 1 && next_node < NODE_MAX)
        begin
            a = heap_pop();
            b = heap_pop();
            k = next_node - leaves;
            zero_node[k] = a;
            one_node[k] = b;
            node_weight[next_node] = node_weight[a] + node_weight[b];
            heap_push(next_node);
            next_node++;
        end
        first_new = pending_codes.size();
        if (heap_size != 0)
        begin
            w.node = heap_node[0];
            w.code = 0;
            w.depth = 0;
            stack.push_back(w);
            while (stack.size() != 0)
            begin
                w = stack.pop_back();
                if (w.node < leaves)
                begin
                    c.code_symbol = leaf_sym[w.node];
                    c.code_bits = w.code[30:0];
                    c.code_length = w.depth[4:0];
                    c.last_code = 1'b0;
                    c.overflow = symbols_dropped;
                    pending_codes.push_back(c);
                end
                else
                begin
                    k = w.node - leaves;
                    stack.push_back('{one_node[k], (w.code << 1) | 1, w.depth + 1});
                    stack.push_back('{zero_node[k], w.code << 1, w.depth + 1});
                end
            end
            if (pending_codes.size() > first_new)
                pending_codes[pending_codes.size() - 1].last_code = 1'b1;
        end
        heap_size = 0;
        leaf_total = 0;
        symbols_dropped = 1'b0;
    endfunction

    task automatic send_beat(hcb_pkg::sym_beat_t beat, bit typed,
                             hcb_pkg::code_beat_t typed_code);
        sym_valid <= 1'b1;
        sym_data <= beat;
        do
            @(posedge clk);
        while (!sym_ready);
        if (typed)
            pending_codes.push_back(typed_code);
        else
            predict_codes(beat);
        beats_sent++;
        if (beat.last_symbol)
            runs_sent++;
        if (!quiet && $urandom_range(0, 99) < 25)
        begin
            sym_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_symbol(logic [7:0] sym, logic [23:0] freq, bit last);
        send_beat('{sym, freq, last}, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            code_ready <= 1'b0;
        else
            code_ready <= quiet || ($urandom_range(0, 99) >= 25);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d code beats outstanding", $time,
                     pending_codes.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        hcb_pkg::code_beat_t exp;
        if (rst_n && code_valid && code_ready)
        begin
            codes_seen++;
            if (pending_codes.size() == 0)
            begin
                $display("%0t: unexpected code beat, expected none, actual %p", $time,
                         code_data);
                error_count++;
            end
            else
            begin
                exp = pending_codes.pop_front();
                if (exp.code_symbol !== code_data.code_symbol)
                begin
                    $display("%0t: code_symbol expected %0h actual %0h", $time,
                             exp.code_symbol, code_data.code_symbol);
                    error_count++;
                end
                if (exp.code_bits !== code_data.code_bits)
                begin
                    $display("%0t: code_bits expected %0h actual %0h", $time,
                             exp.code_bits, code_data.code_bits);
                    error_count++;
                end
                if (exp.code_length !== code_data.code_length)
                begin
                    $display("%0t: code_length expected %0d actual %0d", $time,
                             exp.code_length, code_data.code_length);
                    error_count++;
                end
                if (exp.last_code !== code_data.last_code)
                begin
                    $display("%0t: last_code expected %0b actual %0b", $time,
                             exp.last_code, code_data.last_code);
                    error_count++;
                end
                if (exp.overflow !== code_data.overflow)
                begin
                    $display("%0t: overflow expected %0b actual %0b", $time,
                             exp.overflow, code_data.overflow);
                    error_count++;
                end
            end
        end
    end

    dir_row_t dir_rows[19] = '{
        '{'{8'hFF, 24'hFFFFFF, 1'b1}, 1'b1, '{8'hFF, 31'd0, 5'd0, 1'b1, 1'b0}},
        '{'{8'h00, 24'h000000, 1'b1}, 1'b1, '{8'h00, 31'd0, 5'd0, 1'b1, 1'b0}},
        '{'{8'h55, 24'hAAAAAA, 1'b1}, 1'b1, '{8'h55, 31'd0, 5'd0, 1'b1, 1'b0}},
        '{'{8'h41, 24'd5, 1'b0}, 1'b0, '0},
        '{'{8'h42, 24'd3, 1'b1}, 1'b0, '0},
        '{'{8'h10, 24'd7, 1'b0}, 1'b0, '0},
        '{'{8'h11, 24'd7, 1'b0}, 1'b0, '0},
        '{'{8'h12, 24'd7, 1'b1}, 1'b0, '0},
        '{'{8'h80, 24'hFFFFFF, 1'b0}, 1'b0, '0},
        '{'{8'h81, 24'hFFFFFF, 1'b0}, 1'b0, '0},
        '{'{8'h82, 24'h000000, 1'b0}, 1'b0, '0},
        '{'{8'h83, 24'h000001, 1'b1}, 1'b0, '0},
        '{'{8'h90, 24'd0, 1'b0}, 1'b0, '0},
        '{'{8'h91, 24'd0, 1'b1}, 1'b0, '0},
        '{'{8'hA0, 24'd100, 1'b0}, 1'b0, '0},
        '{'{8'hA1, 24'd50, 1'b0}, 1'b0, '0},
        '{'{8'hA2, 24'd25, 1'b0}, 1'b0, '0},
        '{'{8'hA3, 24'd12, 1'b0}, 1'b0, '0},
        '{'{8'hA4, 24'd6, 1'b1}, 1'b0, '0}
    };

    initial
    begin
        int          run_len;
        int          freq_mode;
        int          rand_runs;
        int          rand_beats;
        logic [23:0] fa;
        logic [23:0] fb;
        logic [23:0] freq;
        rst_n = 1'b0;
        sym_valid = 1'b0;
        sym_data = '0;
        quiet = 1'b0;
        runs_sent = 0;
        beats_sent = 0;
        heap_size = 0;
        leaf_total = 0;
        symbols_dropped = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].code);

        // Fibonacci weights give the deepest possible tree, 31-bit codes.
        fa = 24'd1;
        fb = 24'd1;
        for (int i = 0; i < hcb_pkg::MAX_SYMBOLS; i++)
        begin
            send_symbol(8'hC0 + i[7:0], fa, i == hcb_pkg::MAX_SYMBOLS - 1);
            freq = fa + fb;
            fa = fb;
            fb = freq;
        end
        // Full heap, then dropped beats; the last beat of each run is itself dropped.
        for (int i = 0; i <= hcb_pkg::MAX_SYMBOLS; i++)
            send_symbol(8'($urandom_range(0, 255)), 24'($urandom_range(0, 24'hFFFFFF)),
                        i == hcb_pkg::MAX_SYMBOLS);
        for (int i = 0; i < hcb_pkg::MAX_SYMBOLS + 4; i++)
            send_symbol(8'($urandom_range(0, 255)), 24'($urandom_range(0, 15)),
                        i == hcb_pkg::MAX_SYMBOLS + 3);

        rand_runs = 0;
        rand_beats = 0;
        while (rand_beats < RAND_ITEMS)
        begin
            quiet = (rand_runs >= 6 && rand_runs < 12);
            if ($urandom_range(0, 9) == 0)
                run_len = $urandom_range(20, hcb_pkg::MAX_SYMBOLS + 4);
            else
                run_len = $urandom_range(1, 10);
            freq_mode = $urandom_range(0, 3);
            for (int i = 0; i < run_len; i++)
            begin
                case (freq_mode)
                    0: freq = 24'($urandom_range(0, 7));
                    1: freq = 24'($urandom_range(0, 255));
                    default: freq = 24'($urandom_range(0, 24'hFFFFFF));
                endcase
                send_symbol(8'($urandom_range(0, 255)), freq, i == run_len - 1);
            end
            rand_beats += run_len;
            rand_runs++;
            if (rand_runs == 3)
            begin
                sym_valid <= 1'b0;
                while (pending_codes.size() != 0)
                    @(posedge clk);
            end
        end
        quiet = 1'b0;
        sym_valid <= 1'b0;

        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Sent %0d symbol beats in %0d runs, including lone symbols, deepest trees",
                 beats_sent, runs_sent);
        $display("and dropped symbols past capacity; checked %0d code beats.", codes_seen);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ huffman_code_builder_unit.f @@
+incdir+sv
sv/hcb_pkg.sv
sv/huffman_code_builder_unit.sv
tb/huffman_code_builder_unit_tb.sv
